@@ hdl/rfv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rfv_pkg;

    // default sizes
    localparam int DEF_NUM_TREES  = 16;
    localparam int DEF_NODE_COUNT = 1024;
    localparam int DEF_MAX_DEPTH  = 16;

    localparam int FEAT_COUNT = 5;
    localparam int QUEUE_DEPTH = 2;

    // request codes
    localparam logic [1:0] REQ_CLASSIFY  = 2'd0;
    localparam logic [1:0] REQ_NODE_WR   = 2'd1;
    localparam logic [1:0] REQ_ROOT_WR   = 2'd2;

    // class codes
    localparam logic signed [1:0] CLS_ZERO = 2'sd0;
    localparam logic signed [1:0] CLS_ONE  = 2'sd1;
    localparam logic signed [1:0] CLS_NONE = -2'sd1;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [9:0]         entry_index;
        logic signed [31:0] node_feature;
        logic signed [31:0] node_threshold;
        logic signed [31:0] node_left;
        logic signed [31:0] node_right;
        logic signed [31:0] root_node;
        logic [63:0]        flow_duration;
        logic [7:0]         transport_protocol;
        logic [63:0]        packet_count;
        logic [63:0]        byte_count;
        logic [17:0]        flag_code;
    } t_req;

    typedef struct packed {
        logic signed [1:0] predicted_class;
        logic [4:0]        votes_zero;
        logic [4:0]        votes_one;
    } t_rsp;

    // one node memory word
    typedef struct packed {
        logic        valid;
        logic [31:0] feature;
        logic [31:0] threshold;
        logic [31:0] left;
        logic [31:0] right;
    } t_node;

    typedef enum logic [1:0] {
        K_CLASSIFY,
        K_NODE_WR,
        K_ROOT_WR,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind                         kind;
        logic [9:0]                    entry_index;
        t_node                         node;
        logic [31:0]                   root_node;
        logic [FEAT_COUNT-1:0][31:0]   feat;
    } t_job;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROOT,
        ST_WALK,
        ST_DONE
    } t_state;

    // x * 10 wrapped to 32 bits
    function automatic logic [31:0] times_ten(input logic [31:0] x);
        return {x[28:0], 3'b000} + {x[30:0], 1'b0};
    endfunction

endpackage

`default_nettype wire

@@ hdl/rfv_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rfv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

@@ hdl/rfv_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rfv_front #(
    parameter int NUM_TREES  = rfv_pkg::DEF_NUM_TREES,
    parameter int NODE_COUNT = rfv_pkg::DEF_NODE_COUNT
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    input  wire rfv_pkg::t_req       i_req,
    output logic                     busy,
    input  wire rfv_pkg::t_back_stat i_stat,
    input  wire logic                i_pop,
    output logic                     o_job_valid,
    output rfv_pkg::t_job            o_job
);

    import rfv_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_push;
    t_job             w_job;
    logic [31:0]      w_idx32;

    assign busy        = (r_cnt == CNT_W'(QUEUE_DEPTH)) || i_stat.clearing;
    assign w_push      = start && !busy;
    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_q[r_rp];
    assign w_idx32     = 32'(i_req.entry_index);

    // sort the request and precompute the scaled features
    always_comb begin
        w_job.entry_index    = i_req.entry_index;
        w_job.node.valid     = 1'b1;
        w_job.node.feature   = i_req.node_feature;
        w_job.node.threshold = i_req.node_threshold;
        w_job.node.left      = i_req.node_left;
        w_job.node.right     = i_req.node_right;
        w_job.root_node      = i_req.root_node;
        w_job.feat[0]        = times_ten(i_req.flow_duration[31:0]);
        w_job.feat[1]        = times_ten(32'(i_req.transport_protocol));
        w_job.feat[2]        = times_ten(i_req.packet_count[31:0]);
        w_job.feat[3]        = times_ten(i_req.byte_count[31:0]);
        w_job.feat[4]        = times_ten(32'(i_req.flag_code));
        unique case (i_req.req_type)
            REQ_CLASSIFY: w_job.kind = K_CLASSIFY;
            REQ_NODE_WR:  w_job.kind = (w_idx32 < 32'(NODE_COUNT)) ? K_NODE_WR : K_NOP;
            REQ_ROOT_WR:  w_job.kind = (w_idx32 < 32'(NUM_TREES)) ? K_ROOT_WR : K_NOP;
            default:      w_job.kind = K_NOP;
        endcase
    end

    always_comb begin
        n_wp  = w_push ? r_wp + PTR_W'(1) : r_wp;
        n_rp  = i_pop ? r_rp + PTR_W'(1) : r_rp;
        n_cnt = r_cnt + CNT_W'(w_push) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_job;
        end
    end

endmodule

`default_nettype wire

@@ hdl/rfv_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rfv_back #(
    parameter int NUM_TREES  = rfv_pkg::DEF_NUM_TREES,
    parameter int NODE_COUNT = rfv_pkg::DEF_NODE_COUNT,
    parameter int MAX_DEPTH  = rfv_pkg::DEF_MAX_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_valid,
    input  wire rfv_pkg::t_job i_job,
    output logic               o_pop,
    output rfv_pkg::t_back_stat o_stat,
    output logic               o_strobe,
    output rfv_pkg::t_rsp      o_rsp
);

    import rfv_pkg::*;

    localparam int NODE_AW = $clog2(NODE_COUNT);
    localparam int TREE_W  = (NUM_TREES > 1) ? $clog2(NUM_TREES) : 1;
    localparam int STEP_W  = $clog2(MAX_DEPTH + 1);
    localparam int VOTE_W  = ($clog2(NUM_TREES + 1) > 5) ? $clog2(NUM_TREES + 1) : 5;
    localparam int NODE_WB = $bits(t_node);

    t_state                      r_state, n_state;
    logic [NODE_AW-1:0]          r_clr, n_clr;
    logic [NUM_TREES-1:0]        r_root_valid, n_root_valid;
    logic [TREE_W-1:0]           r_tree, n_tree;
    logic [STEP_W-1:0]           r_step, n_step;
    logic [31:0]                 r_cur, n_cur;
    logic                        r_have, n_have;
    logic [VOTE_W-1:0]           r_v0, n_v0;
    logic [VOTE_W-1:0]           r_v1, n_v1;
    logic [FEAT_COUNT-1:0][31:0] r_feat, n_feat;
    logic                        r_strobe, n_strobe;
    t_rsp                        r_rsp, n_rsp;

    logic               node_we;
    logic [NODE_AW-1:0] node_addr;
    logic [NODE_WB-1:0] node_wdata;
    logic [NODE_WB-1:0] node_rdata;
    logic               root_we;
    logic [TREE_W-1:0]  root_addr;
    logic [31:0]        root_wdata;
    logic [31:0]        root_rdata;

    t_node             w_node;
    logic              w_hit;
    logic              w_inner;
    logic              w_vote;
    logic [31:0]       w_sel;
    logic [31:0]       w_next;
    logic [31:0]       w_visit;
    logic              w_in_range;
    logic              w_tree_end;
    logic              w_last_tree;
    logic [TREE_W-1:0] w_job_tree;
    logic              w_is_cls;

    rfv_ram #(
        .WIDTH (NODE_WB),
        .DEPTH (NODE_COUNT),
        .AW    (NODE_AW)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_addr  (node_addr),
        .i_wdata (node_wdata),
        .o_rdata (node_rdata)
    );

    rfv_ram #(
        .WIDTH (32),
        .DEPTH (NUM_TREES),
        .AW    (TREE_W)
    ) u_root_ram (
        .i_clk   (i_clk),
        .i_we    (root_we),
        .i_addr  (root_addr),
        .i_wdata (root_wdata),
        .o_rdata (root_rdata)
    );

    // one walk step on the node word read last cycle
    always_comb begin
        w_node  = t_node'(node_rdata);
        w_hit   = r_have && w_node.valid;
        w_inner = w_hit && (w_node.feature < 32'(FEAT_COUNT));
        w_vote  = w_hit && !w_inner && (w_node.threshold < 32'd2);
        unique case (w_node.feature[2:0])
            3'd1:    w_sel = r_feat[1];
            3'd2:    w_sel = r_feat[2];
            3'd3:    w_sel = r_feat[3];
            3'd4:    w_sel = r_feat[4];
            default: w_sel = r_feat[0];
        endcase
        if (w_inner) begin
            w_next = ($signed(w_sel) < $signed(w_node.threshold)) ? w_node.left
                                                                  : w_node.right;
        end else begin
            w_next = r_cur;
        end
        w_visit     = (r_state == ST_ROOT) ? root_rdata : w_next;
        w_in_range  = (w_visit < 32'(NODE_COUNT));
        w_tree_end  = w_vote || (r_step == STEP_W'(MAX_DEPTH));
        w_last_tree = (r_tree == TREE_W'(NUM_TREES - 1));
        w_job_tree  = TREE_W'(32'(i_job.entry_index));
        w_is_cls    = i_job_valid && (i_job.kind == K_CLASSIFY);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == NODE_AW'(NODE_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_is_cls) begin
                    n_state = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (r_root_valid[r_tree]) begin
                    n_state = ST_WALK;
                end else if (w_last_tree) begin
                    n_state = ST_DONE;
                end
            end
            ST_WALK: begin
                if (w_tree_end) begin
                    n_state = w_last_tree ? ST_DONE : ST_ROOT;
                end
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // memory control and datapath
    always_comb begin
        node_we      = 1'b0;
        node_addr    = w_visit[NODE_AW-1:0];
        node_wdata   = i_job.node;
        root_we      = 1'b0;
        root_addr    = r_tree + TREE_W'(1);
        root_wdata   = i_job.root_node;
        o_pop        = 1'b0;
        n_clr        = r_clr;
        n_root_valid = r_root_valid;
        n_tree       = r_tree;
        n_step       = r_step;
        n_cur        = r_cur;
        n_have       = r_have;
        n_v0         = r_v0;
        n_v1         = r_v1;
        n_feat       = r_feat;
        n_strobe     = 1'b0;
        n_rsp        = r_rsp;
        unique case (r_state)
            ST_CLEAR: begin
                node_we    = 1'b1;
                node_addr  = r_clr;
                node_wdata = '0;
                n_clr      = r_clr + NODE_AW'(1);
            end
            ST_IDLE: begin
                if (i_job_valid) begin
                    o_pop = 1'b1;
                    n_rsp = '{predicted_class: CLS_NONE, votes_zero: 5'd0, votes_one: 5'd0};
                    unique case (i_job.kind)
                        K_CLASSIFY: begin
                            root_addr = '0;
                            n_tree    = '0;
                            n_v0      = '0;
                            n_v1      = '0;
                            n_feat    = i_job.feat;
                        end
                        K_NODE_WR: begin
                            node_we   = 1'b1;
                            node_addr = NODE_AW'(32'(i_job.entry_index));
                            n_strobe  = 1'b1;
                        end
                        K_ROOT_WR: begin
                            root_we                  = 1'b1;
                            root_addr                = w_job_tree;
                            n_root_valid[w_job_tree] = 1'b1;
                            n_strobe                 = 1'b1;
                        end
                        default: n_strobe = 1'b1;
                    endcase
                end
            end
            ST_ROOT: begin
                if (r_root_valid[r_tree]) begin
                    n_cur  = root_rdata;
                    n_step = '0;
                    n_have = w_in_range;
                end else begin
                    n_tree = r_tree + TREE_W'(1);
                end
            end
            ST_WALK: begin
                if (w_vote) begin
                    if (w_node.threshold[0]) begin
                        n_v1 = r_v1 + VOTE_W'(1);
                    end else begin
                        n_v0 = r_v0 + VOTE_W'(1);
                    end
                end
                if (w_tree_end) begin
                    n_tree = r_tree + TREE_W'(1);
                end else begin
                    n_cur  = w_next;
                    n_step = r_step + STEP_W'(1);
                    n_have = w_in_range;
                end
            end
            ST_DONE: begin
                n_strobe        = 1'b1;
                n_rsp.votes_zero = r_v0[4:0];
                n_rsp.votes_one  = r_v1[4:0];
                if (r_v0 != '0) begin
                    n_rsp.predicted_class = (r_v1 > r_v0) ? CLS_ONE : CLS_ZERO;
                end else if (r_v1 != '0) begin
                    n_rsp.predicted_class = CLS_ONE;
                end else begin
                    n_rsp.predicted_class = CLS_NONE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr        <= '0;
            r_root_valid <= '0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_root_valid <= n_root_valid;
            r_strobe     <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tree <= n_tree;
        r_step <= n_step;
        r_cur  <= n_cur;
        r_have <= n_have;
        r_v0   <= n_v0;
        r_v1   <= n_v1;
        r_feat <= n_feat;
        r_rsp  <= n_rsp;
    end

    assign o_stat.clearing = (r_state == ST_CLEAR);
    assign o_strobe        = r_strobe;
    assign o_rsp           = r_rsp;

endmodule

`default_nettype wire

@@ hdl/random_forest_vote_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// random forest vote engine
// requests come in on start/i_req and are taken at a clock edge with start high
// and busy low. a request either writes one node entry, writes one tree root,
// or classifies a flow given by five counters (each scaled by ten).
// every request returns exactly one response on o_rsp, marked by o_strobe for
// a single cycle; the receiver cannot hold it off, so it must take it then.
// a two-entry request queue sits between the intake and the tree walker, so
// busy only rises while that queue is full or the node store is being cleared.
// with the walker idle, a write is at the queue head the cycle after it is
// taken and answers in the cycle after that; while the walker stays idle,
// writes stream at one a cycle. a classify holds the walker while it walks
// each tree in turn, and answers in the cycle after the done state; each walk step
// is one read of the single-port node memory, and each tree adds one root
// memory read.
// reset: after i_rst_n is released the walker clears the valid marks of all
// NODE_COUNT node memory entries, one address after another, with busy held
// high; all tree roots come out of reset invalid.

module random_forest_vote_top #(
    parameter int NUM_TREES  = rfv_pkg::DEF_NUM_TREES,
    parameter int NODE_COUNT = rfv_pkg::DEF_NODE_COUNT,
    parameter int MAX_DEPTH  = rfv_pkg::DEF_MAX_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire rfv_pkg::t_req i_req,
    output logic               busy,
    output logic               o_strobe,
    output rfv_pkg::t_rsp      o_rsp
);

    import rfv_pkg::*;

    // queue head toward the walker
    logic       job_valid;
    t_job       job;
    logic       job_pop;
    // walker status back to the intake
    t_back_stat back_stat;

    // intake: sorts each request, scales the features, queues it
    rfv_front #(
        .NUM_TREES  (NUM_TREES),
        .NODE_COUNT (NODE_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_req       (i_req),
        .busy        (busy),
        .i_stat      (back_stat),
        .i_pop       (job_pop),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    // walker: owns the node and root memories, runs writes and tree walks
    rfv_back #(
        .NUM_TREES  (NUM_TREES),
        .NODE_COUNT (NODE_COUNT),
        .MAX_DEPTH  (MAX_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_pop       (job_pop),
        .o_stat      (back_stat),
        .o_strobe    (o_strobe),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire
